[src/fca_pkg.sv]
`default_nettype none

package fca_pkg;

    localparam int LEN_W   = 32;
    localparam int BS_W    = 17;
    localparam int ACT_W   = 11;
    localparam int IDX_W   = 10;
    localparam int WORD_W  = 32;
    localparam int NEXT_W  = 30;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam logic [WORD_W-1:0] END_MARK = 32'd9999;

    localparam logic [BS_W-1:0]  BLOCK_SIZE_RST = 17'd64;
    localparam logic [ACT_W-1:0] ACTIVE_RST     = 11'd1024;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE     = 1'b1;

    // Datapath actions issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CLEAR,
        ACT_LATCH,
        ACT_COUNT,
        ACT_DIV,
        ACT_NOSPACE,
        ACT_ALLOC_INIT,
        ACT_ALLOC,
        ACT_END,
        ACT_RANGE,
        ACT_RD,
        ACT_ENTRY
    } t_act;

    typedef struct packed {
        logic              clr_last;
        logic              count_done;
        logic              div_done;
        logic              alloc_done;
        logic              idx_oob;
        logic              too_few;
        logic              blocks_zero;
        logic [FUNC_W-1:0] func;
    } t_sts;

endpackage

`default_nettype wire

[src/fca_ram.sv]
`default_nettype none

module fca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/fca_div.sv]
`default_nettype none

module fca_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [fca_pkg::LEN_W-1:0] i_dividend,
    input  logic [fca_pkg::BS_W-1:0]  i_divisor,
    output logic                     o_done,
    output logic [fca_pkg::LEN_W-1:0] o_quot,
    output logic [fca_pkg::BS_W-1:0]  o_rem
);
    import fca_pkg::*;

    localparam int IT_W = $clog2(LEN_W);
    localparam logic [IT_W-1:0] IT_LAST = IT_W'(LEN_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [IT_W-1:0]  r_it;
    logic [LEN_W-1:0] r_q;
    logic [BS_W-1:0]  r_rem;
    logic [BS_W-1:0]  r_dvs;
    logic [BS_W:0]    part;
    logic [BS_W:0]    diff;
    logic             ge;

    // Restoring division, one quotient bit per cycle; dividend bits shift out
    // of the top of r_q while quotient bits shift in at the bottom.
    always_comb begin
        part = {r_rem, r_q[LEN_W-1]};
        diff = part - {1'b0, r_dvs};
        ge   = (part >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_it   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_it   <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[LEN_W-2:0], ge};
                r_rem <= ge ? diff[BS_W-1:0] : part[BS_W-1:0];
                r_it  <= r_it + IT_W'(1);
                if (r_it == IT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[src/fca_dp.sv]
`default_nettype none

module fca_dp #(
    parameter int TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fca_pkg::t_act                 i_act,
    output fca_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_we,
    input  logic [fca_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fca_pkg::BS_W-1:0]      i_cfg_data,
    input  logic [fca_pkg::FUNC_W-1:0]    i_func,
    input  logic [fca_pkg::LEN_W-1:0]     i_data_length,
    input  logic [fca_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [fca_pkg::WORD_W-1:0]    i_entry_word,
    output logic [fca_pkg::STAT_W-1:0]    o_status,
    output logic [fca_pkg::IDX_W-1:0]     o_start_index,
    output logic [fca_pkg::LEN_W-1:0]     o_blocks_needed,
    output logic [fca_pkg::NEXT_W-1:0]    o_next_index,
    output logic                          o_entry_is_end,
    output logic                          o_entry_is_free,
    output logic [fca_pkg::ACT_W-1:0]     o_free_count
);
    import fca_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = (AW + 1 > ACT_W) ? AW + 1 : ACT_W;
    localparam logic [CW-1:0] TE_CNT   = CW'(TABLE_ENTRIES);
    localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_ENTRIES - 1);

    logic [BS_W-1:0]   r_block_size;
    logic [ACT_W-1:0]  r_active;
    logic [FUNC_W-1:0] r_func;
    logic [LEN_W-1:0]  r_len;
    logic [IDX_W-1:0]  r_idx;
    logic [WORD_W-1:0] r_word;
    logic [AW-1:0]     r_clr;
    logic [CW-1:0]     r_scan;
    logic [CW-1:0]     r_didx;
    logic              r_pv;
    logic [ACT_W-1:0]  r_cnt;
    logic [ACT_W-1:0]  r_taken;
    logic [AW-1:0]     r_prev;
    logic [LEN_W-1:0]  r_blocks;
    logic [STAT_W-1:0] r_status;
    logic [IDX_W-1:0]  r_start;
    logic [NEXT_W-1:0] r_next;
    logic              r_is_end;
    logic              r_is_free;

    logic [CW-1:0]     active_ext;
    logic [CW-1:0]     n_act;
    logic [CW-1:0]     idx_ext;
    logic [AW-1:0]     idx_addr;
    logic              issue;
    logic              hit;
    logic              take;
    logic              scanning;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [BS_W-1:0]   bs_eff;
    logic              div_done;
    logic [LEN_W-1:0]  div_quot;
    logic [BS_W-1:0]   div_rem;

    always_comb begin
        active_ext = CW'(r_active);
        n_act      = (active_ext > TE_CNT) ? TE_CNT : active_ext;
        idx_ext    = CW'(r_idx);
        idx_addr   = idx_ext[AW-1:0];
        issue      = (r_scan < n_act);
        hit        = r_pv && (ram_rdata == '0);
        scanning   = (i_act == ACT_COUNT) || (i_act == ACT_ALLOC);
        take       = (i_act == ACT_ALLOC) && hit && (r_taken != r_blocks[ACT_W-1:0]);
        bs_eff     = (r_block_size == '0) ? BS_W'(1) : r_block_size;
    end

    // One write port: clearing pass, chain links (the previous entry learns its
    // successor when the next free entry turns up), the end mark, raw writes.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_prev;
        ram_wdata = END_MARK;
        unique case (i_act)
            ACT_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            ACT_ALLOC: begin
                ram_we    = take && (r_taken != '0);
                ram_wdata = WORD_W'(r_didx) << 2;
            end
            ACT_END: begin
                ram_we = 1'b1;
            end
            ACT_ENTRY: begin
                ram_we    = (r_func == FUNC_WRITE);
                ram_waddr = idx_addr;
                ram_wdata = r_word;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        ram_raddr = (i_act == ACT_RD) ? idx_addr : r_scan[AW-1:0];
    end

    fca_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    fca_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_act == ACT_DIV),
        .i_dividend(r_len),
        .i_divisor (bs_eff),
        .o_done    (div_done),
        .o_quot    (div_quot),
        .o_rem     (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BLOCK_SIZE_RST;
            r_active     <= ACTIVE_RST;
            r_clr        <= '0;
            r_pv         <= 1'b0;
            r_scan       <= '0;
            r_taken      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BLOCK_SIZE) begin
                    r_block_size <= i_cfg_data;
                end else begin
                    r_active <= i_cfg_data[ACT_W-1:0];
                end
            end

            // Reads are issued one per cycle while scanning; r_pv marks the registered
            // data as it comes back from the RAM, r_didx the entry it belongs to.
            if (scanning) begin
                r_pv   <= issue;
                r_didx <= r_scan;
                if (issue) begin
                    r_scan <= r_scan + CW'(1);
                end
            end

            if (div_done) begin
                r_blocks <= div_quot + LEN_W'(div_rem != '0);
            end

            unique case (i_act)
                ACT_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                end
                ACT_LATCH: begin
                    r_func    <= i_func;
                    r_len     <= i_data_length;
                    r_idx     <= i_entry_index;
                    r_word    <= i_entry_word;
                    r_scan    <= '0;
                    r_pv      <= 1'b0;
                    r_cnt     <= '0;
                    r_status  <= STATUS_OK;
                    r_start   <= '0;
                    r_blocks  <= '0;
                    r_next    <= '0;
                    r_is_end  <= 1'b0;
                    r_is_free <= 1'b0;
                end
                ACT_COUNT: begin
                    if (hit) begin
                        r_cnt <= r_cnt + ACT_W'(1);
                    end
                end
                ACT_ALLOC_INIT: begin
                    r_scan  <= '0;
                    r_pv    <= 1'b0;
                    r_taken <= '0;
                end
                ACT_ALLOC: begin
                    if (take) begin
                        if (r_taken == '0) begin
                            r_start <= r_didx[IDX_W-1:0];
                        end
                        r_prev  <= r_didx[AW-1:0];
                        r_taken <= r_taken + ACT_W'(1);
                    end
                end
                ACT_END: begin
                    r_cnt <= r_cnt - r_blocks[ACT_W-1:0];
                end
                ACT_NOSPACE: begin
                    r_status <= STATUS_NOSPACE;
                end
                ACT_RANGE: begin
                    r_status <= STATUS_RANGE;
                end
                ACT_ENTRY: begin
                    if (r_func == FUNC_READ) begin
                        r_next    <= ram_rdata[WORD_W-1:2];
                        r_is_end  <= (ram_rdata == END_MARK);
                        r_is_free <= (ram_rdata == '0);
                    end else begin
                        if ((ram_rdata == '0) && (r_word != '0)) begin
                            r_cnt <= r_cnt - ACT_W'(1);
                        end else if ((ram_rdata != '0) && (r_word == '0)) begin
                            r_cnt <= r_cnt + ACT_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_sts.clr_last    = (r_clr == CLR_LAST);
        o_sts.count_done  = !r_pv && !issue;
        o_sts.div_done    = div_done;
        o_sts.alloc_done  = (r_taken == r_blocks[ACT_W-1:0]);
        o_sts.idx_oob     = (idx_ext >= n_act);
        o_sts.too_few     = (r_blocks > LEN_W'(r_cnt));
        o_sts.blocks_zero = (r_blocks == '0);
        o_sts.func        = r_func;
    end

    assign o_status        = r_status;
    assign o_start_index   = r_start;
    assign o_blocks_needed = r_blocks;
    assign o_next_index    = r_next;
    assign o_entry_is_end  = r_is_end;
    assign o_entry_is_free = r_is_free;
    assign o_free_count    = r_cnt;

endmodule

`default_nettype wire

[src/fca_ctrl.sv]
`default_nettype none

module fca_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  fca_pkg::t_sts i_sts,
    output fca_pkg::t_act o_act,
    output logic          o_busy,
    output logic          o_valid
);
    import fca_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_COUNT,
        S_DIV,
        S_DIV_WAIT,
        S_CHECK,
        S_ALLOC,
        S_ALLOC_END,
        S_RANGE,
        S_ENTRY_RD,
        S_ENTRY
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        o_act   = ACT_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_act = ACT_CLEAR;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_act   = ACT_LATCH;
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                o_act = ACT_COUNT;
                if (i_sts.count_done) begin
                    priority if (i_sts.func == FUNC_ALLOC) begin
                        n_state = S_DIV;
                    end else if ((i_sts.func == FUNC_READ) || (i_sts.func == FUNC_WRITE)) begin
                        n_state = i_sts.idx_oob ? S_RANGE : S_ENTRY_RD;
                    end else begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_act   = ACT_DIV;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_sts.too_few) begin
                    o_act   = ACT_NOSPACE;
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end else if (i_sts.blocks_zero) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end else begin
                    o_act   = ACT_ALLOC_INIT;
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                o_act = ACT_ALLOC;
                if (i_sts.alloc_done) begin
                    n_state = S_ALLOC_END;
                end
            end
            S_ALLOC_END: begin
                o_act   = ACT_END;
                n_state = S_IDLE;
                n_valid = 1'b1;
            end
            S_RANGE: begin
                o_act   = ACT_RANGE;
                n_state = S_IDLE;
                n_valid = 1'b1;
            end
            S_ENTRY_RD: begin
                o_act   = ACT_RD;
                n_state = S_ENTRY;
            end
            S_ENTRY: begin
                o_act   = ACT_ENTRY;
                n_state = S_IDLE;
                n_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

[src/fat_chain_allocator.sv]
// Channel  | Ports                                         | Beat taken when
// ---------+-----------------------------------------------+------------------------
// command  | start, i_func, i_data_length, i_entry_index,  | start high, busy low
//          | i_entry_word                                  |
// result   | o_valid, o_status, o_start_index,             | every cycle o_valid is
//          | o_blocks_needed, o_next_index, o_entry_is_end,| high (one cycle each)
//          | o_entry_is_free, o_free_count                 |
// config   | i_cfg_we, i_cfg_idx, i_cfg_data               | i_cfg_we high
//
// After reset the table is swept to zero, one entry a cycle, while busy stays
// high. Every command first recounts the free entries over the n active
// entries through the table's read port. An in-range read or write then
// reads the entry and acts on it; allocate adds the bit-serial block-count
// divider and the first-fit scan. The result beat appears the cycle busy
// falls; the receiver cannot stall it.
`default_nettype none

module fat_chain_allocator #(
    parameter int TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fca_pkg::FUNC_W-1:0]    i_func,
    input  logic [fca_pkg::LEN_W-1:0]     i_data_length,
    input  logic [fca_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [fca_pkg::WORD_W-1:0]    i_entry_word,
    output logic                          o_valid,
    output logic [fca_pkg::STAT_W-1:0]    o_status,
    output logic [fca_pkg::IDX_W-1:0]     o_start_index,
    output logic [fca_pkg::LEN_W-1:0]     o_blocks_needed,
    output logic [fca_pkg::NEXT_W-1:0]    o_next_index,
    output logic                          o_entry_is_end,
    output logic                          o_entry_is_free,
    output logic [fca_pkg::ACT_W-1:0]     o_free_count,
    input  logic                          i_cfg_we,
    input  logic [fca_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fca_pkg::BS_W-1:0]      i_cfg_data
);
    import fca_pkg::*;

    t_act act;
    t_sts sts;

    fca_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (sts),
        .o_act  (act),
        .o_busy (busy),
        .o_valid(o_valid)
    );

    fca_dp #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_act          (act),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_data_length  (i_data_length),
        .i_entry_index  (i_entry_index),
        .i_entry_word   (i_entry_word),
        .o_status       (o_status),
        .o_start_index  (o_start_index),
        .o_blocks_needed(o_blocks_needed),
        .o_next_index   (o_next_index),
        .o_entry_is_end (o_entry_is_end),
        .o_entry_is_free(o_entry_is_free),
        .o_free_count   (o_free_count)
    );

endmodule

`default_nettype wire

[dv/tb_fat_chain_allocator.sv]
`timescale 1ns / 1ps

module tb_fat_chain_allocator;
    import fca_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int unsigned TBL_DEPTH = TABLE_ENTRIES_DEF;
    localparam int unsigned RUN_LIMIT_NS = 60_000_000;
    localparam int unsigned DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [LEN_W-1:0]  len;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] word;
    } t_fat_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  start_idx;
        logic [LEN_W-1:0]  blocks;
        logic [NEXT_W-1:0] next_idx;
        logic              is_end;
        logic              is_free;
        logic [ACT_W-1:0]  free_cnt;
    } t_fat_reply;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              cmd_start = 1'b0;
    logic              cmd_busy;
    logic [FUNC_W-1:0] cmd_func = FUNC_READ;
    logic [LEN_W-1:0]  cmd_len = '0;
    logic [IDX_W-1:0]  cmd_idx = '0;
    logic [WORD_W-1:0] cmd_word = '0;

    logic              cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_BLOCK_SIZE;
    logic [BS_W-1:0]   cfg_data = '0;

    logic              res_valid;
    logic [STAT_W-1:0] res_status;
    logic [IDX_W-1:0]  res_start_idx;
    logic [LEN_W-1:0]  res_blocks;
    logic [NEXT_W-1:0] res_next_idx;
    logic              res_is_end;
    logic              res_is_free;
    logic [ACT_W-1:0]  res_free_cnt;

    // Shadow copy of the allocation table and its registers.
    logic [WORD_W-1:0] fat_tbl [0:TBL_DEPTH-1];
    logic [BS_W-1:0]   blk_size = BLOCK_SIZE_RST;
    logic [ACT_W-1:0]  act_entries = ACTIVE_RST;
    logic [IDX_W-1:0]  chain_cursor = '0;

    t_fat_cmd   pend_q[$];
    t_fat_reply reply_q[$];
    int         beats_in = 0;
    int         mismatches = 0;

    fat_chain_allocator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .start           (cmd_start),
        .busy            (cmd_busy),
        .i_func          (cmd_func),
        .i_data_length   (cmd_len),
        .i_entry_index   (cmd_idx),
        .i_entry_word    (cmd_word),
        .o_valid         (res_valid),
        .o_status        (res_status),
        .o_start_index   (res_start_idx),
        .o_blocks_needed (res_blocks),
        .o_next_index    (res_next_idx),
        .o_entry_is_end  (res_is_end),
        .o_entry_is_free (res_is_free),
        .o_free_count    (res_free_cnt),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned live_entries();
        return (act_entries > TBL_DEPTH) ? TBL_DEPTH : 32'(act_entries);
    endfunction

    function automatic int unsigned free_in_use();
        int unsigned n;
        int unsigned cnt;
        n = live_entries();
        cnt = 0;
        for (int unsigned i = 0; i < n; i++)
            if (fat_tbl[i] == '0) cnt++;
        return cnt;
    endfunction

    // Applies one command to the shadow table and returns the reply it must produce.
    function automatic t_fat_reply apply_fat_op(input t_fat_cmd c);
        t_fat_reply r;
        int unsigned n;
        int unsigned avail;
        int unsigned bs;
        int unsigned b;
        int unsigned taken;
        int unsigned prev;
        logic [WORD_W-1:0] w;
        r = '0;
        n = live_entries();
        avail = free_in_use();
        case (c.func)
            FUNC_ALLOC: begin
                bs = (blk_size == '0) ? 1 : 32'(blk_size);
                b = c.len / bs;
                if (c.len % bs != 0) b++;
                r.blocks = b;
                if (b > avail) begin
                    r.status = STATUS_NOSPACE;
                end else if (b > 0) begin
                    taken = 0;
                    prev = 0;
                    for (int unsigned i = 0; i < n && taken < b; i++) begin
                        if (fat_tbl[i] == '0) begin
                            if (taken == 0) begin
                                r.start_idx = IDX_W'(i);
                                chain_cursor = IDX_W'(i);
                            end else begin
                                fat_tbl[prev] = i * 4;
                            end
                            fat_tbl[i] = END_MARK;
                            prev = i;
                            taken++;
                        end
                    end
                end
            end
            FUNC_READ, FUNC_WRITE: begin
                if (c.idx >= n) begin
                    r.status = STATUS_RANGE;
                end else if (c.func == FUNC_READ) begin
                    w = fat_tbl[c.idx];
                    r.next_idx = w[WORD_W-1:2];
                    r.is_end = (w == END_MARK);
                    r.is_free = (w == '0);
                    // Walk the chain on later reads where the entry points somewhere.
                    if (!r.is_end && !r.is_free) chain_cursor = w[IDX_W+1:2];
                end else begin
                    fat_tbl[c.idx] = c.word;
                end
            end
            default: ;
        endcase
        r.free_cnt = ACT_W'(free_in_use());
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] aim_index(input int unsigned n);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 4 && n > 0) return chain_cursor;
        if (roll < 9 && n > 0) return IDX_W'($urandom_range(0, n - 1));
        return IDX_W'($urandom_range(0, TBL_DEPTH - 1));
    endfunction

    function automatic t_fat_cmd pick_random_cmd();
        t_fat_cmd c;
        int unsigned n;
        int unsigned roll;
        int unsigned bs;
        int unsigned b;
        int unsigned room;
        int unsigned wsel;
        bit crowded;
        n = live_entries();
        crowded = (free_in_use() * 4 < n);
        // Unused fields carry noise; the block must ignore them.
        c.func = FUNC_READ;
        c.len = $urandom();
        c.idx = IDX_W'($urandom());
        c.word = $urandom();
        roll = $urandom_range(0, 99);
        // A nearly full table is mostly released again so allocation keeps succeeding.
        if (crowded) roll = (roll < 20) ? roll * 2 : (roll < 40) ? 45 + (roll - 20) / 2
                                                   : (roll < 95) ? 70 + (roll - 40) * 25 / 55
                                                   : roll;
        bs = (blk_size == '0) ? 1 : 32'(blk_size);
        if (roll < 40) begin
            c.func = FUNC_ALLOC;
            if ($urandom_range(0, 9) != 0) begin
                room = free_in_use() + 2;
                if (room > 12) room = 12;
                b = $urandom_range(0, room);
                c.len = (b == 0) ? 0 : (b - 1) * bs + $urandom_range(1, bs);
            end
        end else if (roll < 70) begin
            c.func = FUNC_READ;
            c.idx = aim_index(n);
        end else if (roll < 95) begin
            c.func = FUNC_WRITE;
            c.idx = aim_index(n);
            wsel = $urandom_range(0, 9);
            if (crowded || wsel < 5) c.word = '0;
            else if (wsel < 7) c.word = END_MARK;
            else if (wsel < 9) c.word = $urandom_range(0, (n > 0) ? n - 1 : 0) * 4;
        end else begin
            c.func = FUNC_UNUSED;
        end
        return c;
    endfunction

    function automatic bit hold_off();
        if (beats_in >= 150 && beats_in < 260) return 1'b0;
        return $urandom_range(0, 99) < 26;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    always @(posedge clk) begin : drive
        logic go;
        go = cmd_start;
        if (!rst_n) begin
            go = 1'b0;
        end else begin
            if (cmd_start && !cmd_busy) begin
                reply_q.push_back(apply_fat_op(pend_q.pop_front()));
                beats_in++;
                go = 1'b0;
            end
            if (!go && pend_q.size() != 0 && !hold_off()) begin
                cmd_func <= pend_q[0].func;
                cmd_len  <= pend_q[0].len;
                cmd_idx  <= pend_q[0].idx;
                cmd_word <= pend_q[0].word;
                go = 1'b1;
            end
        end
        cmd_start <= go;
    end

    always @(posedge clk) begin : watch
        t_fat_reply want;
        if (rst_n && res_valid) begin
            if (reply_q.size() == 0) begin
                flag_mismatch("result beat with nothing pending", 32'(res_status), 0);
            end else begin
                want = reply_q.pop_front();
                if (res_status !== want.status)
                    flag_mismatch("status", 32'(res_status), 32'(want.status));
                if (res_start_idx !== want.start_idx)
                    flag_mismatch("start_index", 32'(res_start_idx), 32'(want.start_idx));
                if (res_blocks !== want.blocks)
                    flag_mismatch("blocks_needed", res_blocks, want.blocks);
                if (res_next_idx !== want.next_idx)
                    flag_mismatch("next_index", 32'(res_next_idx), 32'(want.next_idx));
                if (res_is_end !== want.is_end)
                    flag_mismatch("entry_is_end", 32'(res_is_end), 32'(want.is_end));
                if (res_is_free !== want.is_free)
                    flag_mismatch("entry_is_free", 32'(res_is_free), 32'(want.is_free));
                if (res_free_cnt !== want.free_cnt)
                    flag_mismatch("free_count", 32'(res_free_cnt), 32'(want.free_cnt));
            end
        end
    end

    task automatic push_cmd(input logic [FUNC_W-1:0] func, input int unsigned len,
                            input int unsigned idx, input int unsigned word);
        t_fat_cmd c;
        c.func = func;
        c.len = LEN_W'(len);
        c.idx = IDX_W'(idx);
        c.word = WORD_W'(word);
        pend_q.push_back(c);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BS_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BLOCK_SIZE) blk_size = val;
        else act_entries = val[ACT_W-1:0];
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || reply_q.size() != 0 || cmd_busy) @(negedge clk);
    endtask

    task automatic run_phase(input logic [BS_W-1:0] bs, input logic [BS_W-1:0] act,
                             input int count);
        t_fat_cmd c;
        wait_drained();
        repeat (4) @(negedge clk);
        write_reg(CFG_BLOCK_SIZE, bs);
        write_reg(CFG_ACTIVE, act);
        // One command in flight at a time, so each pick sees the table it will hit.
        for (int k = 0; k < count; k++) begin
            while (pend_q.size() != 0) @(negedge clk);
            c = pick_random_cmd();
            pend_q.push_back(c);
        end
    endtask

    initial begin
        for (int i = 0; i < TBL_DEPTH; i++) fat_tbl[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings: block size 64, full table.
        push_cmd(FUNC_READ,  0, 0, 0);
        push_cmd(FUNC_ALLOC, 0, 0, 0);
        push_cmd(FUNC_ALLOC, 1, 0, 0);
        push_cmd(FUNC_ALLOC, 192, 0, 0);
        push_cmd(FUNC_READ,  0, 1, 0);
        push_cmd(FUNC_READ,  0, 3, 0);
        push_cmd(FUNC_WRITE, 0, 2, 0);
        push_cmd(FUNC_ALLOC, 65, 0, 0);
        push_cmd(FUNC_READ,  0, 2, 0);
        push_cmd(FUNC_WRITE, 0, 10'h3FF, 32'hFFFF_FFFF);
        push_cmd(FUNC_READ,  0, 10'h3FF, 0);
        push_cmd(FUNC_WRITE, 0, 10'h3FE, END_MARK);
        push_cmd(FUNC_READ,  0, 10'h3FE, 0);
        push_cmd(FUNC_ALLOC, 32'hFFFF_FFFF, 0, 0);
        // Exactly the remaining free entries, then one block too many.
        push_cmd(FUNC_ALLOC, 1017 * 64, 0, 0);
        push_cmd(FUNC_ALLOC, 1, 0, 0);
        push_cmd(FUNC_UNUSED, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
        push_cmd(FUNC_WRITE, 0, 500, 0);
        push_cmd(FUNC_READ,  0, 500, 0);
        push_cmd(FUNC_ALLOC, 64, 0, 0);
        push_cmd(FUNC_READ,  0, 500, 0);

        run_phase(17'd1,      17'd16,    60);
        run_phase(17'd7,      17'd1,     30);
        // Only the low bits of the active count register are kept.
        run_phase(17'h1FFFF,  17'h1F825, 50);
        run_phase(17'd0,      17'd100,   60);
        run_phase(17'd512,    17'd0,     20);
        run_phase(17'd3,      17'd2047,  40);
        run_phase(17'd65536,  17'd300,   60);
        run_phase(17'd13,     17'd1024,  40);
        run_phase(17'd100,    17'd50,    80);
        run_phase(17'd2,      17'd8,     60);

        while (pend_q.size() != 0 || reply_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && reply_q.size() == 0) begin
            $display("fat_chain_allocator: match");
        end else begin
            $display("fat_chain_allocator: mismatch");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("fat_chain_allocator: mismatch");
        $finish;
    end

endmodule
